### sv/sfs_pkg.sv
// Package for the sprite frame sequencer: sizes, codes, control types and helpers.
package sfs_pkg;

  // Table depth and width of the time accumulator.
  localparam int MAX_FRAMES = 16;
  localparam int TIME_BITS  = 24;

  // Field widths fixed by the interface.
  localparam int CMD_W   = 3;
  localparam int DT_W    = 16;
  localparam int SETV_W  = 24;
  localparam int SLOT_W  = 4;
  localparam int DUR_W   = 16;
  localparam int SPEED_W = 16;
  localparam int FC_W    = 5;
  localparam int TOT_W   = 20;
  localparam int CFG_W   = 20;
  localparam int CFGI_W  = 3;
  localparam int OFI_W   = 4;
  localparam int OTIME_W = 24;

  // Derived widths.
  localparam int FIDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int PROD_W  = DT_W + SPEED_W;
  localparam int FRAC_W  = 8;
  localparam int SCL_W   = PROD_W - FRAC_W;
  localparam int ACC_W   = DUR_W + FIDX_W + 1;
  localparam int MAX_AB  = (TIME_BITS > SCL_W) ? TIME_BITS : SCL_W;
  localparam int MAX_ABC = (MAX_AB > ACC_W) ? MAX_AB : ACC_W;
  localparam int MAX_ALL = (MAX_ABC > TOT_W) ? MAX_ABC : TOT_W;
  localparam int WIDE_W  = MAX_ALL + 1;
  localparam int DCNT_W  = $clog2(TIME_BITS + 1);

  localparam logic [WIDE_W-1:0] TIME_MAX_W = WIDE_W'((65'd1 << TIME_BITS) - 65'd1);

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 3'd0,
    CMD_PLAY      = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_PAUSE     = 3'd3,
    CMD_RESUME    = 3'd4,
    CMD_SET_TIME  = 3'd5,
    CMD_SET_FRAME = 3'd6,
    CMD_LOAD      = 3'd7
  } cmd_t;

  // Playback states.
  typedef enum logic [1:0] {
    RUN_STOPPED  = 2'd0,
    RUN_PLAYING  = 2'd1,
    RUN_PAUSED   = 2'd2,
    RUN_FINISHED = 2'd3
  } run_t;

  // Configuration register indexes.
  typedef enum logic [CFGI_W-1:0] {
    CFG_FRAME_COUNT = 3'd0,
    CFG_LOOPING     = 3'd1,
    CFG_REVERSED    = 3'd2,
    CFG_SPEED       = 3'd3,
    CFG_TOTAL       = 3'd4
  } cfg_idx_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ADD,
    S_CHK,
    S_DIV,
    S_SEARCH,
    S_SUMF,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic add;
    logic check;
    logic div_take;
    logic search_step;
    logic sum_step;
  } sfs_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic tick_ok;
    logic set_ok;
    logic total_zero;
    logic over_total;
    logic looping;
    logic div_done;
    logic search_end;
    logic sum_end;
  } sfs_sts_t;

  // Clamp a wide value to the time maximum.
  function automatic logic [TIME_BITS-1:0] sat_time(input logic [WIDE_W-1:0] v);
    logic [TIME_BITS-1:0] r;
    if (v > TIME_MAX_W) begin
      r = {TIME_BITS{1'b1}};
    end else begin
      r = v[TIME_BITS-1:0];
    end
    return r;
  endfunction

endpackage

### sv/sfs_rem.sv
// Restoring remainder unit: time modulo clip length, one dividend bit per cycle.
module sfs_rem import sfs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] dividend,
  input  logic [TOT_W-1:0]     divisor,
  output logic                 done,
  output logic [TOT_W-1:0]     remainder
);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [TOT_W:0]    rem_r, rem_nxt;
  logic [TIME_BITS-1:0] q_r, q_nxt;
  logic [TOT_W:0]    shifted;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    shifted  = {rem_r[TOT_W-1:0], q_r[TIME_BITS-1]};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = DCNT_W'(TIME_BITS);
      rem_nxt = '0;
      q_nxt   = dividend;
    end else if (run_r) begin
      if (shifted >= {1'b0, divisor}) begin
        rem_nxt = shifted - {1'b0, divisor};
      end else begin
        rem_nxt = shifted;
      end
      q_nxt   = {q_r[TIME_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r[TOT_W-1:0];

endmodule

### sv/sfs_dp.sv
// Datapath of the sprite frame sequencer: registers, frame table, arithmetic and walks.
module sfs_dp import sfs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  sfs_ctl_t            ctl,
  output sfs_sts_t            sts,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [DT_W-1:0]     in_delta_time,
  input  logic [SETV_W-1:0]   in_set_value,
  input  logic [SLOT_W-1:0]   in_entry_slot,
  input  logic [DUR_W-1:0]    in_entry_duration,
  input  logic                in_entry_event,
  input  logic                cfg_we,
  input  logic [CFGI_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  output logic [OFI_W-1:0]    out_frame_index,
  output logic [1:0]          out_play_state,
  output logic [OTIME_W-1:0]  out_current_time,
  output logic                out_looped,
  output logic                out_finished,
  output logic                out_frame_event_hit
);

  typedef struct packed {
    logic             evt;
    logic [DUR_W-1:0] dur;
  } entry_t;

  // Configuration registers.
  logic [FC_W-1:0]    frame_count_r;
  logic               looping_r;
  logic               reversed_r;
  logic [SPEED_W-1:0] speed_r;
  logic [TOT_W-1:0]   total_r;

  // Latched transaction.
  cmd_t              cmd_r;
  logic [DT_W-1:0]   dt_r;
  logic [SETV_W-1:0] set_r;
  logic [SLOT_W-1:0] slot_r;
  logic [DUR_W-1:0]  edur_r;
  logic              eevt_r;

  // Playback state and working registers.
  run_t                 run_r, run_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [FIDX_W-1:0]    cur_r, cur_nxt;
  logic                 looped_r, looped_nxt;
  logic                 fin_r, fin_nxt;
  logic                 evt_r, evt_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [WIDE_W-1:0]    acc_r, acc_nxt;
  logic [CNT_W-1:0]     i_r, i_nxt;

  entry_t table_r [MAX_FRAMES];

  logic [CNT_W-1:0]  n;
  logic              over_total;
  logic [WIDE_W-1:0] time_sum;
  logic              tick_mode;
  logic [CNT_W-1:0]  idx_wide;
  logic [FIDX_W-1:0] idx;
  entry_t            ent;
  logic [WIDE_W-1:0] acc_sum;
  logic              in_range;
  logic              hit;
  logic [FIDX_W-1:0] clamp_frame;
  logic              load_ok;
  logic              div_start;
  logic              div_done;
  logic [TOT_W-1:0]  div_rem;

  // Frames in use, end-of-clip compare and the scaled time advance.
  always_comb begin
    if (32'(frame_count_r) > MAX_FRAMES) begin
      n = CNT_W'(MAX_FRAMES);
    end else begin
      n = CNT_W'(frame_count_r);
    end
    over_total = WIDE_W'(time_r) >= WIDE_W'(total_r);
    time_sum   = WIDE_W'(time_r) + WIDE_W'(prod_r[PROD_W-1:FRAC_W]);
  end

  // One step of the table walk: ticks honor the direction, other walks go forward.
  always_comb begin
    tick_mode = (cmd_r == CMD_TICK);
    if (tick_mode && reversed_r) begin
      idx_wide = n - CNT_W'(1) - i_r;
    end else begin
      idx_wide = i_r;
    end
    idx      = FIDX_W'(idx_wide);
    ent      = table_r[idx];
    acc_sum  = acc_r + WIDE_W'(ent.dur);
    in_range = i_r < n;
    hit      = in_range && (WIDE_W'(time_r) <= acc_sum);
    if (32'(set_r) > 32'(n) - 32'd1) begin
      clamp_frame = FIDX_W'(n - CNT_W'(1));
    end else begin
      clamp_frame = FIDX_W'(set_r);
    end
    load_ok = 32'(slot_r) < MAX_FRAMES;
  end

  assign div_start = ctl.check && over_total && looping_r;

  sfs_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (time_r),
    .divisor   (total_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Next values of the playback state for each controller command.
  always_comb begin
    run_nxt    = run_r;
    time_nxt   = time_r;
    cur_nxt    = cur_r;
    looped_nxt = looped_r;
    fin_nxt    = fin_r;
    evt_nxt    = evt_r;
    prod_nxt   = prod_r;
    acc_nxt    = acc_r;
    i_nxt      = i_r;
    if (ctl.exec) begin
      looped_nxt = 1'b0;
      fin_nxt    = 1'b0;
      evt_nxt    = 1'b0;
      acc_nxt    = '0;
      i_nxt      = '0;
      unique case (cmd_r)
        CMD_TICK: begin
          prod_nxt = PROD_W'(dt_r) * PROD_W'(speed_r);
        end
        CMD_PLAY: begin
          run_nxt = RUN_PLAYING;
          if (over_total && !looping_r) begin
            time_nxt = '0;
            cur_nxt  = '0;
          end
        end
        CMD_STOP: begin
          run_nxt  = RUN_STOPPED;
          time_nxt = '0;
          cur_nxt  = '0;
        end
        CMD_PAUSE: begin
          if (run_r == RUN_PLAYING) begin
            run_nxt = RUN_PAUSED;
          end
        end
        CMD_RESUME: begin
          if (run_r == RUN_PAUSED) begin
            run_nxt = RUN_PLAYING;
          end
        end
        CMD_SET_TIME: begin
          time_nxt = sat_time(WIDE_W'(set_r));
          cur_nxt  = '0;
        end
        CMD_SET_FRAME: begin
          if (n != '0) begin
            cur_nxt = clamp_frame;
          end
        end
        CMD_LOAD: begin
        end
      endcase
    end else if (ctl.add) begin
      time_nxt = sat_time(time_sum);
    end else if (ctl.check) begin
      // A non-looping clip past its end finishes on the last frame.
      if (over_total && !looping_r) begin
        time_nxt = sat_time(WIDE_W'(total_r));
        cur_nxt  = FIDX_W'(n - CNT_W'(1));
        run_nxt  = RUN_FINISHED;
        fin_nxt  = 1'b1;
      end
    end else if (ctl.div_take) begin
      time_nxt   = TIME_BITS'(div_rem);
      looped_nxt = 1'b1;
    end else if (ctl.search_step) begin
      if (in_range) begin
        acc_nxt = acc_sum;
        i_nxt   = i_r + CNT_W'(1);
      end
      if (hit) begin
        if (tick_mode) begin
          if (idx != cur_r) begin
            cur_nxt = idx;
            evt_nxt = ent.evt;
          end
        end else begin
          cur_nxt = idx;
        end
      end
    end else if (ctl.sum_step) begin
      // Time of a set frame is the sum of the durations before it.
      if (i_r == CNT_W'(cur_r)) begin
        time_nxt = sat_time(acc_r);
      end else begin
        acc_nxt = acc_sum;
        i_nxt   = i_r + CNT_W'(1);
      end
    end
  end

  // Control and playback registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= '0;
      looping_r     <= 1'b1;
      reversed_r    <= 1'b0;
      speed_r       <= SPEED_W'(256);
      total_r       <= '0;
      run_r         <= RUN_STOPPED;
      time_r        <= '0;
      cur_r         <= '0;
      looped_r      <= 1'b0;
      fin_r         <= 1'b0;
      evt_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_COUNT: frame_count_r <= cfg_wdata[FC_W-1:0];
          CFG_LOOPING:     looping_r     <= cfg_wdata[0];
          CFG_REVERSED:    reversed_r    <= cfg_wdata[0];
          CFG_SPEED:       speed_r       <= cfg_wdata[SPEED_W-1:0];
          CFG_TOTAL:       total_r       <= cfg_wdata[TOT_W-1:0];
          default: begin
          end
        endcase
      end
      run_r    <= run_nxt;
      time_r   <= time_nxt;
      cur_r    <= cur_nxt;
      looped_r <= looped_nxt;
      fin_r    <= fin_nxt;
      evt_r    <= evt_nxt;
    end
  end

  // Working registers and the latched transaction.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    i_r    <= i_nxt;
    if (ctl.accept) begin
      cmd_r  <= cmd_t'(in_cmd);
      dt_r   <= in_delta_time;
      set_r  <= in_set_value;
      slot_r <= in_entry_slot;
      edur_r <= in_entry_duration;
      eevt_r <= in_entry_event;
    end
  end

  // Frame table write on load entry.
  always_ff @(posedge clk) begin
    if (ctl.exec && (cmd_r == CMD_LOAD) && load_ok) begin
      table_r[FIDX_W'(slot_r)] <= '{evt: eevt_r, dur: edur_r};
    end
  end

  // Status to the controller.
  always_comb begin
    sts.cmd        = cmd_r;
    sts.tick_ok    = (run_r == RUN_PLAYING) && (n != '0);
    sts.set_ok     = (n != '0);
    sts.total_zero = (total_r == '0);
    sts.over_total = over_total;
    sts.looping    = looping_r;
    sts.div_done   = div_done;
    sts.search_end = !in_range || hit;
    sts.sum_end    = (i_r == CNT_W'(cur_r));
  end

  // Result fields come straight from the state registers.
  assign out_frame_index     = OFI_W'(cur_r);
  assign out_play_state      = run_r;
  assign out_current_time    = OTIME_W'(time_r);
  assign out_looped          = looped_r;
  assign out_finished        = fin_r;
  assign out_frame_event_hit = evt_r;

endmodule

### sv/sfs_ctrl.sv
// Controller state machine of the sprite frame sequencer.
module sfs_ctrl import sfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  sfs_sts_t sts,
  output sfs_ctl_t ctl,
  output logic     busy,
  output logic     out_valid
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE, S_DONE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EXEC: begin
        unique case (sts.cmd)
          CMD_TICK:      state_nxt = sts.tick_ok ? S_ADD : S_DONE;
          CMD_SET_TIME:  state_nxt = S_SEARCH;
          CMD_SET_FRAME: state_nxt = sts.set_ok ? S_SUMF : S_DONE;
          default:       state_nxt = S_DONE;
        endcase
      end
      S_ADD: begin
        state_nxt = sts.total_zero ? S_DONE : S_CHK;
      end
      S_CHK: begin
        if (sts.over_total) begin
          state_nxt = sts.looping ? S_DIV : S_DONE;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.search_end) begin
          state_nxt = S_DONE;
        end
      end
      S_SUMF: begin
        if (sts.sum_end) begin
          state_nxt = S_DONE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs: a new transaction may be taken while the previous result is shown.
  always_comb begin
    busy            = !((state_r == S_IDLE) || (state_r == S_DONE));
    out_valid       = (state_r == S_DONE);
    ctl.accept      = start && !busy;
    ctl.exec        = (state_r == S_EXEC);
    ctl.add         = (state_r == S_ADD);
    ctl.check       = (state_r == S_CHK);
    ctl.div_take    = (state_r == S_DIV) && sts.div_done;
    ctl.search_step = (state_r == S_SEARCH);
    ctl.sum_step    = (state_r == S_SUMF);
  end

endmodule

### sv/sprite_frame_sequencer_unit.sv
// Top level of the sprite frame sequencer: controller, datapath and checks.
//
// One command transaction is taken when start is high and busy is low; its single
// result appears on the out_ ports for one cycle with out_valid high, and the
// receiver cannot stall it. Play, stop, pause, resume and load entry go from the
// exec state straight to the result cycle. Set time walks the table, and set frame
// sums the durations before the chosen frame when frames are in use; each table
// walk takes one entry per cycle. A tick that does not advance goes straight to
// the result; one that advances adds the scaled time and, with a nonzero clip
// length, checks the clip end, then walks the table unless the clip finishes,
// first waiting for the bit-serial remainder unit when the time wraps. A new
// command may be accepted in the result cycle. Configuration writes are taken at
// any cycle with cfg_we high and must be made while no command is in progress.
module sprite_frame_sequencer_unit import sfs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [DT_W-1:0]     in_delta_time,
  input  logic [SETV_W-1:0]   in_set_value,
  input  logic [SLOT_W-1:0]   in_entry_slot,
  input  logic [DUR_W-1:0]    in_entry_duration,
  input  logic                in_entry_event,
  output logic                out_valid,
  output logic [OFI_W-1:0]    out_frame_index,
  output logic [1:0]          out_play_state,
  output logic [OTIME_W-1:0]  out_current_time,
  output logic                out_looped,
  output logic                out_finished,
  output logic                out_frame_event_hit,
  input  logic                cfg_we,
  input  logic [CFGI_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  sfs_ctl_t ctl;
  sfs_sts_t sts;

  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  sfs_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .sts                 (sts),
    .in_cmd              (in_cmd),
    .in_delta_time       (in_delta_time),
    .in_set_value        (in_set_value),
    .in_entry_slot       (in_entry_slot),
    .in_entry_duration   (in_entry_duration),
    .in_entry_event      (in_entry_event),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_frame_index     (out_frame_index),
    .out_play_state      (out_play_state),
    .out_current_time    (out_current_time),
    .out_looped          (out_looped),
    .out_finished        (out_finished),
    .out_frame_event_hit (out_frame_event_hit)
  );

`ifndef SYNTHESIS
  // A result never shows in the cycle right after its transaction is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result strobe directly after acceptance");

  // Each result is strobed for a single cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A tick cannot both wrap and finish the clip.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_looped && out_finished))
    else $error("looped and finished raised together");

  // A finished result always reports the finished play state.
  a_finish_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |-> (out_play_state == RUN_FINISHED))
    else $error("finished flag without finished state");
`endif

endmodule
